// ----- src/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
package bcc_pkg;

    // Event codes held per button and returned by a read
    typedef enum logic [2:0] {
        EV_OPEN     = 3'd0,
        EV_CLICKED  = 3'd1,
        EV_DOUBLE   = 3'd2,
        EV_HELD     = 3'd3,
        EV_RELEASED = 3'd4
    } event_t;

    // Item commands
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_READ = 1'b1
    } command_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACTIVE_LEVEL  = 3'd0,
        REG_PRESENT_MASK  = 3'd1,
        REG_HOLD_TICKS    = 3'd2,
        REG_DOUBLE_WINDOW = 3'd3,
        REG_DOUBLE_ENABLE = 3'd4,
        REG_HOLD_ENABLE   = 3'd5
    } cfg_index_t;

    // Pins that exist on the item
    localparam int PIN_COUNT = 3;

    // Window value loaded in single-click mode
    localparam int SINGLE_CLICK_WINDOW = 1;

    // Reset values of the configuration registers
    localparam logic                 RST_ACTIVE_LEVEL  = 1'b0;
    localparam logic [PIN_COUNT-1:0] RST_PRESENT_MASK  = 3'd7;
    localparam logic [15:0]          RST_HOLD_TICKS    = 16'd100;
    localparam logic [15:0]          RST_DOUBLE_WINDOW = 16'd60;
    localparam logic                 RST_DOUBLE_ENABLE = 1'b1;
    localparam logic                 RST_HOLD_ENABLE   = 1'b1;

    // Configuration seen by every button
    typedef struct packed {
        logic                 active_level;
        logic [PIN_COUNT-1:0] present_mask;
        logic [15:0]          hold_ticks;
        logic [15:0]          double_window_ticks;
        logic                 double_enable;
        logic                 hold_enable;
    } cfg_t;

endpackage

// ----- src/bcc_cfg.sv -----
// Configuration register file of the button click classifier.
module bcc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bcc_pkg::cfg_t                   cfg
);

    bcc_pkg::cfg_t cfg_reg;
    bcc_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (bcc_pkg::cfg_index_t'(cfg_index))
                bcc_pkg::REG_ACTIVE_LEVEL:  cfg_next.active_level = cfg_data[0];
                bcc_pkg::REG_PRESENT_MASK:
                    cfg_next.present_mask = cfg_data[bcc_pkg::PIN_COUNT-1:0];
                bcc_pkg::REG_HOLD_TICKS:    cfg_next.hold_ticks = cfg_data;
                bcc_pkg::REG_DOUBLE_WINDOW: cfg_next.double_window_ticks = cfg_data;
                bcc_pkg::REG_DOUBLE_ENABLE: cfg_next.double_enable = cfg_data[0];
                bcc_pkg::REG_HOLD_ENABLE:   cfg_next.hold_enable = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level        <= bcc_pkg::RST_ACTIVE_LEVEL;
            cfg_reg.present_mask        <= bcc_pkg::RST_PRESENT_MASK;
            cfg_reg.hold_ticks          <= bcc_pkg::RST_HOLD_TICKS;
            cfg_reg.double_window_ticks <= bcc_pkg::RST_DOUBLE_WINDOW;
            cfg_reg.double_enable       <= bcc_pkg::RST_DOUBLE_ENABLE;
            cfg_reg.hold_enable         <= bcc_pkg::RST_HOLD_ENABLE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/bcc_button.sv -----
// Per-button state and tick/read update of the button click classifier.
module bcc_button #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  bcc_pkg::cfg_t   cfg,
    input  logic            tick_en,
    input  logic            level,
    input  logic            clear_en,
    output bcc_pkg::event_t event_code
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    bcc_pkg::event_t        event_reg,  event_next;
    logic [COUNT_WIDTH-1:0] down_reg,   down_next;
    logic [COUNT_WIDTH-1:0] window_reg, window_next;

    logic [COUNT_WIDTH-1:0] down_inc;
    logic [COUNT_WIDTH-1:0] window_mid;
    logic [COUNT_WIDTH-1:0] window_load;
    bcc_pkg::event_t        event_mid;

    assign down_inc    = (down_reg == CNT_MAX) ? down_reg : down_reg + 1'b1;
    assign window_load = cfg.double_enable
                       ? COUNT_WIDTH'(cfg.double_window_ticks)
                       : COUNT_WIDTH'(bcc_pkg::SINGLE_CLICK_WINDOW);

    // Apply a tick or a read-clear
    always_comb begin
        event_mid   = event_reg;
        window_mid  = window_reg;
        down_next   = down_reg;
        event_next  = event_reg;
        window_next = window_reg;
        if (tick_en) begin
            if (level == cfg.active_level) begin
                // pressed: count down ticks, promote to held past the threshold
                down_next = down_inc;
                if ((CMP_W'(down_inc) > CMP_W'(cfg.hold_ticks)) && cfg.hold_enable) begin
                    event_mid = bcc_pkg::EV_HELD;
                end
            end else begin
                // released: classify the press just ended
                if (down_reg > COUNT_WIDTH'(1)) begin
                    if (event_reg == bcc_pkg::EV_HELD) begin
                        event_mid  = bcc_pkg::EV_RELEASED;
                        window_mid = '0;
                    end else if (window_reg > COUNT_WIDTH'(bcc_pkg::SINGLE_CLICK_WINDOW)) begin
                        if (window_reg < COUNT_WIDTH'(cfg.double_window_ticks)) begin
                            event_mid  = bcc_pkg::EV_DOUBLE;
                            window_mid = '0;
                        end
                    end else begin
                        window_mid = window_load;
                    end
                end
                down_next = '0;
            end
            // run the click window down; expiry reports a click
            event_next  = event_mid;
            window_next = window_mid;
            if (window_mid != '0) begin
                window_next = window_mid - 1'b1;
                if (window_mid == COUNT_WIDTH'(1)) begin
                    event_next = bcc_pkg::EV_CLICKED;
                end
            end
        end else if (clear_en) begin
            if (event_reg != bcc_pkg::EV_HELD && event_reg != bcc_pkg::EV_OPEN) begin
                event_next = bcc_pkg::EV_OPEN;
            end
        end
    end

    // Hold the button state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_reg  <= bcc_pkg::EV_OPEN;
            down_reg   <= '0;
            window_reg <= '0;
        end else begin
            event_reg  <= event_next;
            down_reg   <= down_next;
            window_reg <= window_next;
        end
    end

    assign event_code = event_reg;

endmodule

// ----- src/button_click_classifier.sv -----
// Top level of the button click classifier: item stage, buttons and result register.
// Classifies click, double-click, held and released events for up to BUTTONS buttons
// (only the first three have a pin bit and a present bit). A tick item (command 0)
// updates every wired button with its present bit set and returns no result; a read
// item (command 1) returns the event of button s_which and clears it to open unless
// it is held; an index of BUTTONS or more reads open. The block takes one item per
// cycle unless a read waits for the result slot: an item is captured in an input
// register and then handled by the per-button update logic, and a read's result is
// then held in the result register. A waiting result stalls only further reads;
// ticks pass it by. Write configuration only while no item is in flight.
module button_click_classifier #(
    parameter int BUTTONS     = 3,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [2:0]                      s_levels,
    input  logic [1:0]                      s_which,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_button_event
);

    bcc_pkg::cfg_t cfg;

    logic                   stage_valid_reg, stage_valid_next;
    bcc_pkg::command_t      stage_cmd_reg;
    logic [2:0]             stage_levels_reg;
    logic [1:0]             stage_which_reg;
    logic                   out_valid_reg, out_valid_next;
    bcc_pkg::event_t        out_event_reg, out_event_next;

    logic                   out_free;
    logic                   stage_go;
    logic                   is_read;
    logic                   is_tick;
    logic [BUTTONS-1:0]     read_hit;
    bcc_pkg::event_t        event_code [BUTTONS];
    logic [2:0]             read_event;

    bcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: a read needs a free result slot, a tick never waits
    assign out_free = !out_valid_reg || m_ready;
    assign is_read  = stage_cmd_reg == bcc_pkg::CMD_READ;
    assign is_tick  = stage_cmd_reg == bcc_pkg::CMD_TICK;
    assign stage_go = stage_valid_reg && (is_tick || out_free);
    assign s_ready  = !stage_valid_reg || stage_go;

    // Per-button state
    for (genvar i = 0; i < BUTTONS; i++) begin : g_button
        logic tick_en;
        logic level;
        if (i < bcc_pkg::PIN_COUNT) begin : g_pin
            assign tick_en = stage_go && is_tick && cfg.present_mask[i];
            assign level   = stage_levels_reg[i];
        end else begin : g_nopin
            assign tick_en = 1'b0;
            assign level   = 1'b0;
        end
        assign read_hit[i] = is_read && (32'(stage_which_reg) == i);

        bcc_button #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_button (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cfg        (cfg),
            .tick_en    (tick_en),
            .level      (level),
            .clear_en   (stage_go && read_hit[i]),
            .event_code (event_code[i])
        );
    end

    // Select the read button's event; an index out of range reads open
    always_comb begin
        read_event = 3'(bcc_pkg::EV_OPEN);
        for (int i = 0; i < BUTTONS; i++) begin
            if (read_hit[i]) begin
                read_event = event_code[i];
            end
        end
    end

    // Advance the input stage and the result register
    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_valid && s_ready) begin
            stage_valid_next = 1'b1;
        end else if (stage_go) begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (stage_go && is_read) begin
            out_valid_next = 1'b1;
            out_event_next = bcc_pkg::event_t'(read_event);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_cmd_reg    <= bcc_pkg::command_t'(s_command);
            stage_levels_reg <= s_levels;
            stage_which_reg  <= s_which;
        end
        out_event_reg <= out_event_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_button_event = out_event_reg;

endmodule
